// ===== hw/rtl/usc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitising copy: shared package
// Result kinds, the result beat type and the lead byte decoder.
// ----------------------------------------------------------------------------
package usc_pkg;

  // Result kind codes as they appear on the output channel.
  localparam logic [1:0] KindData   = 2'd0;
  localparam logic [1:0] KindTerm   = 2'd1;
  localparam logic [1:0] KindNoRoom = 2'd2;

  // Substitute for a bad lead byte or a byte of a broken sequence.
  localparam logic [7:0] SubstChar = 8'h5F;

  // Destination size after reset.
  localparam logic [15:0] CapacityReset = 16'd1024;

  // Number of result beats one input byte can give.
  localparam int unsigned MaxResults = 4;

  // Number of bytes an incomplete sequence can leave waiting.
  localparam int unsigned HeldDepth = 3;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } usc_result_t;

  // Sequence length announced by a lead byte, or zero if it is no lead byte.
  function automatic logic [2:0] usc_lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/utf8_sanitizing_copy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitising copy
// Copies a zero-terminated byte string, replacing bad UTF-8 lead bytes and the
// bytes of broken sequences with '_', up to a configured destination size.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one source byte per beat; a zero byte ends the
//   string. The output channel gives data bytes, then one terminator beat
//   whose kind tells whether the zero could be written. run_last_o marks the
//   final result beat caused by one input byte. capacity_q is written through
//   cfg_wr_en_i / cfg_wr_data_i; the user must do so only while the block is
//   idle, as the block itself does not enforce it. Each accepted byte is
//   decoded in the cycle it arrives and its results (none to four) are
//   loaded into a small result buffer, so the first result appears in the
//   cycle after acceptance. The buffer drains one beat a cycle while the
//   receiver does not stall. A byte giving at most one result lets the next
//   byte in the cycle its result leaves; one giving more keeps the input
//   stalled until its last result leaves, as the buffer has one output port.
//   Reset clears the held sequence, the write count and the buffer, and sets
//   the capacity to 1024. While the receiver stalls, the current beat holds
//   and the input stalls for as long as the buffer is not empty.
// ----------------------------------------------------------------------------
module utf8_sanitizing_copy (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_kind_o,
  output logic        run_last_o
);

  import usc_pkg::*;

  logic [15:0] capacity_q;
  logic [7:0]  held_q [HeldDepth];
  logic [7:0]  held_d [HeldDepth];
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [2:0]  exp_len_q, exp_len_d;
  logic [15:0] written_q, written_d;

  usc_result_t res_q [MaxResults];
  usc_result_t res_d [MaxResults];
  logic [2:0]  res_cnt_q, res_cnt_d;

  logic        in_acc;
  logic        out_take;
  logic [2:0]  lead_len;
  logic        is_cont;
  logic [7:0]  cand [MaxResults];
  logic [2:0]  cand_n;
  logic        term;
  logic [15:0] room;
  logic [2:0]  emit_n;
  logic [15:0] written_sum;
  usc_result_t ent [MaxResults];
  logic [2:0]  ent_n;

  // Handshake: take a new byte once the buffer is empty or its last beat leaves.
  assign out_take   = out_valid_o && !out_stall_i;
  assign in_stall_o = (res_cnt_q > 3'd1) || ((res_cnt_q == 3'd1) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = (res_cnt_q != 3'd0);
  assign out_byte_o  = res_q[0].data;
  assign out_kind_o  = res_q[0].kind;
  assign run_last_o  = (res_cnt_q == 3'd1);

  // Decode of the arriving byte against the held sequence.
  always_comb begin
    lead_len   = usc_lead_len(in_byte_i);
    is_cont    = (in_byte_i[7:6] == 2'b10);
    cand_n     = 3'd0;
    term       = 1'b0;
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    for (int i = 0; i < MaxResults; i++) begin
      cand[i] = SubstChar;
    end

    if (in_byte_i == 8'd0) begin
      // End of string: every held byte becomes '_' and a terminator follows.
      cand_n     = {1'b0, held_cnt_q};
      term       = 1'b1;
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
      for (int i = 0; i < HeldDepth; i++) begin
        held_d[i] = 8'd0;
      end
    end else if (held_cnt_q == 2'd0) begin
      // Nothing held: the byte is a lead byte.
      if (lead_len == 3'd1) begin
        cand[0] = in_byte_i;
        cand_n  = 3'd1;
      end else if (lead_len == 3'd0) begin
        cand_n = 3'd1;
      end else begin
        held_d[0]  = in_byte_i;
        held_cnt_d = 2'd1;
        exp_len_d  = lead_len;
      end
    end else if (is_cont) begin
      if (({1'b0, held_cnt_q} + 3'd1) >= exp_len_q) begin
        // Sequence complete: copy the held bytes and this one.
        for (int i = 0; i < HeldDepth; i++) begin
          cand[i] = (i < int'(held_cnt_q)) ? held_q[i] : in_byte_i;
        end
        cand[MaxResults - 1] = in_byte_i;
        cand_n     = {1'b0, held_cnt_q} + 3'd1;
        held_cnt_d = 2'd0;
        exp_len_d  = 3'd0;
        for (int i = 0; i < HeldDepth; i++) begin
          held_d[i] = 8'd0;
        end
      end else begin
        held_d[held_cnt_q] = in_byte_i;
        held_cnt_d         = held_cnt_q + 2'd1;
      end
    end else begin
      // Broken sequence: held bytes become '_', then the byte starts afresh.
      for (int i = 0; i < HeldDepth; i++) begin
        held_d[i] = 8'd0;
      end
      held_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
      if (lead_len == 3'd1) begin
        cand[held_cnt_q] = in_byte_i;
        cand_n           = {1'b0, held_cnt_q} + 3'd1;
      end else if (lead_len == 3'd0) begin
        cand_n = {1'b0, held_cnt_q} + 3'd1;
      end else begin
        cand_n     = {1'b0, held_cnt_q};
        held_d[0]  = in_byte_i;
        held_cnt_d = 2'd1;
        exp_len_d  = lead_len;
      end
    end
  end

  // Capacity limit: only a prefix of the data bytes fits.
  always_comb begin
    room        = (written_q < capacity_q) ? (capacity_q - written_q) : 16'd0;
    emit_n      = (room >= {13'd0, cand_n}) ? cand_n : room[2:0];
    written_sum = written_q + {13'd0, emit_n};
    written_d   = term ? 16'd0 : written_sum;
    for (int i = 0; i < MaxResults; i++) begin
      ent[i].data = cand[i];
      ent[i].kind = KindData;
    end
    if (term) begin
      ent[emit_n[1:0]].data = 8'd0;
      ent[emit_n[1:0]].kind = (written_sum < capacity_q) ? KindTerm : KindNoRoom;
    end
    ent_n = emit_n + {2'd0, term};
  end

  // Result buffer: loaded on acceptance, shifted as beats leave.
  always_comb begin
    res_d     = res_q;
    res_cnt_d = res_cnt_q;
    if (in_acc) begin
      res_d     = ent;
      res_cnt_d = ent_n;
    end else if (out_take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
      res_cnt_d = res_cnt_q - 3'd1;
    end
  end

  // Control state and capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
      written_q  <= 16'd0;
      res_cnt_q  <= 3'd0;
      for (int i = 0; i < HeldDepth; i++) begin
        held_q[i] <= 8'd0;
      end
    end else begin
      if (cfg_wr_en_i) begin
        capacity_q <= cfg_wr_data_i;
      end
      if (in_acc) begin
        held_q     <= held_d;
        held_cnt_q <= held_cnt_d;
        exp_len_q  <= exp_len_d;
        written_q  <= written_d;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// ===== hw/rtl/usc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitising copy: port checker
// Watches the ports of the top level and flags behaviour over time.
// ----------------------------------------------------------------------------
module usc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_wr_en_i,
  input logic [15:0] cfg_wr_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  in_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic [1:0]  out_kind_o,
  input logic        run_last_o
);

  import usc_pkg::*;

  // A stalled result beat holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(out_kind_o) && $stable(run_last_o))
    else $error("stalled result beat changed");

  // A terminator beat carries a zero byte and closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == KindTerm || out_kind_o == KindNoRoom) |->
      out_byte_o == 8'd0 && run_last_o)
    else $error("terminator beat malformed");

  // The end of a string always gives a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_byte_i == 8'd0 |=> out_valid_o)
    else $error("zero byte gave no result");

  // More beats of the same run pending keep the input stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> in_stall_o)
    else $error("input taken while a run is still draining");

endmodule

bind utf8_sanitizing_copy usc_checker u_usc_checker (.*);
